// ===== sv/sorted_time_floor_search_unit_defines.svh =====
// assertion macros shared by the checker files
// clock and reset are taken from the enclosing scope as i_clk and i_rst_n
`ifndef SORTED_TIME_FLOOR_SEARCH_UNIT_DEFINES_SVH
`define SORTED_TIME_FLOOR_SEARCH_UNIT_DEFINES_SVH

// checked only while out of reset
`define STFS_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("stfs assertion failed");

// checked at every edge, reset included
`define STFS_ASSERT_RST(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("stfs reset assertion failed");

`endif

// ===== sv/stfs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stfs_pkg
// Shared widths, operation codes and the command word of the time search unit.
// ----------------------------------------------------------------------------
package stfs_pkg;

    localparam int TIME_W              = 64;
    localparam int SLOT_W              = 10;
    localparam int COUNT_W             = 11;
    localparam int DEFAULT_TABLE_DEPTH = 1024;
    localparam int QUEUE_DEPTH         = 2;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef struct packed {
        logic              op;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] tval;
    } t_cmd;

endpackage

// ===== sv/stfs_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stfs_front
// Input register: accepts words, sorts them into table writes and lookups,
// and drops writes aimed past the end of the table.
// ----------------------------------------------------------------------------
module stfs_front #(
    parameter int TABLE_DEPTH = stfs_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_mode,
    input  logic [stfs_pkg::SLOT_W-1:0]   i_entry_index,
    input  logic [stfs_pkg::TIME_W-1:0]   i_time_value,
    output logic                          o_cmd_valid,
    input  logic                          i_cmd_ready,
    output stfs_pkg::t_cmd                o_cmd
);

    logic           r_valid;
    logic           n_valid;
    stfs_pkg::t_cmd r_cmd;
    logic           w_accept;
    logic           w_keep;

    assign o_ready     = !r_valid || i_cmd_ready;
    assign w_accept    = i_valid && o_ready;
    // a write to a slot beyond the table does nothing and gives no word
    assign w_keep      = (i_mode == stfs_pkg::OP_LOOKUP) ||
                         (32'(i_entry_index) < TABLE_DEPTH);
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_comb begin
        n_valid = r_valid;
        if (r_valid && i_cmd_ready) begin
            n_valid = 1'b0;
        end
        if (w_accept && w_keep) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_keep) begin
            r_cmd.op   <= i_mode;
            r_cmd.slot <= i_entry_index;
            r_cmd.tval <= i_time_value;
        end
    end

endmodule

// ===== sv/stfs_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stfs_queue
// Short command queue between the front register and the search engine.
// ----------------------------------------------------------------------------
module stfs_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  stfs_pkg::t_cmd i_cmd,
    output logic           o_valid,
    input  logic           i_ready,
    output stfs_pkg::t_cmd o_cmd
);

    localparam int QD  = stfs_pkg::QUEUE_DEPTH;
    localparam int QAW = (QD > 1) ? $clog2(QD) : 1;
    localparam int QCW = $clog2(QD + 1);

    stfs_pkg::t_cmd   r_mem [QD];
    logic [QAW-1:0]   r_wptr;
    logic [QAW-1:0]   r_rptr;
    logic [QCW-1:0]   r_count;
    logic [QAW-1:0]   n_wptr;
    logic [QAW-1:0]   n_rptr;
    logic [QCW-1:0]   n_count;
    logic             w_push;
    logic             w_pop;

    assign o_ready = (r_count != QCW'(QD));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rptr];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (w_push) begin
            n_wptr = (r_wptr == QAW'(QD - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (w_pop) begin
            n_rptr = (r_rptr == QAW'(QD - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

// ===== sv/stfs_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stfs_back
// Timestamp table memory, entry count register and the search sequencer
// that checks both ends and then halves the span one read at a time.
// ----------------------------------------------------------------------------
module stfs_back #(
    parameter int TABLE_DEPTH = stfs_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [stfs_pkg::COUNT_W-1:0]  i_cfg_wdata,
    input  logic                          i_cmd_valid,
    output logic                          o_cmd_ready,
    input  stfs_pkg::t_cmd                i_cmd,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_in_range,
    output logic [stfs_pkg::SLOT_W-1:0]   o_found_index
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = (AW + 1 > stfs_pkg::COUNT_W) ? AW + 1 : stfs_pkg::COUNT_W;
    localparam int XW = (AW > stfs_pkg::SLOT_W) ? AW : stfs_pkg::SLOT_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LO   = 3'd1;
    localparam logic [2:0] S_HI   = 3'd2;
    localparam logic [2:0] S_MID  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [stfs_pkg::TIME_W-1:0]  r_table [TABLE_DEPTH];
    logic [stfs_pkg::TIME_W-1:0]  r_rdata;
    logic [stfs_pkg::COUNT_W-1:0] r_entry_count;

    logic [2:0]                   r_state;
    logic [2:0]                   n_state;
    logic [stfs_pkg::TIME_W-1:0]  r_key;
    logic [stfs_pkg::TIME_W-1:0]  n_key;
    logic [AW-1:0]                r_lo;
    logic [AW-1:0]                n_lo;
    logic [AW-1:0]                r_hi;
    logic [AW-1:0]                n_hi;
    logic [AW-1:0]                r_mid;
    logic [AW-1:0]                n_mid;
    logic                         r_lo_gt;
    logic                         n_lo_gt;
    logic                         r_res_hit;
    logic                         n_res_hit;
    logic [AW-1:0]                r_res_idx;
    logic [AW-1:0]                n_res_idx;
    logic                         r_out_valid;
    logic                         n_out_valid;
    logic                         r_out_hit;
    logic [stfs_pkg::SLOT_W-1:0]  r_out_idx;
    logic                         w_out_load;

    logic                         w_mem_we;
    logic [AW-1:0]                w_waddr;
    logic [AW-1:0]                w_raddr;
    logic                         w_eq;
    logic                         w_lt;
    logic                         w_gt;
    logic [CW-1:0]                w_cnt_ext;
    logic [AW-1:0]                w_hi_eff;
    logic [AW-1:0]                w_span_lo;
    logic [AW-1:0]                w_span_hi;
    logic [AW:0]                  w_sum;
    logic [AW-1:0]                w_mid;
    logic                         w_wide;
    logic [XW-1:0]                w_idx_ext;

    assign w_eq = (r_rdata == r_key);
    assign w_lt = (r_rdata < r_key);
    assign w_gt = !w_eq && !w_lt;

    // effective count: zero reads as one, large values clamp to the depth
    assign w_cnt_ext = CW'(r_entry_count);
    always_comb begin
        priority if (r_entry_count == '0) begin
            w_hi_eff = '0;
        end else if (w_cnt_ext > CW'(TABLE_DEPTH)) begin
            w_hi_eff = AW'(TABLE_DEPTH - 1);
        end else begin
            w_hi_eff = AW'(w_cnt_ext - 1'b1);
        end
    end

    // span after this probe; in the mid state the compare moves one end
    assign w_span_lo = (r_state == S_MID && w_lt)  ? r_mid : r_lo;
    assign w_span_hi = (r_state == S_MID && !w_lt) ? r_mid : r_hi;
    assign w_sum     = {1'b0, w_span_lo} + {1'b0, w_span_hi};
    assign w_mid     = AW'(w_sum >> 1);
    assign w_wide    = (w_span_hi - w_span_lo) > AW'(1);

    assign w_waddr     = AW'(i_cmd.slot);
    assign o_cmd_ready = (r_state == S_IDLE);
    assign w_out_load  = (r_state == S_OUT) && (!r_out_valid || i_ready);

    always_comb begin
        n_state   = r_state;
        n_key     = r_key;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_mid     = r_mid;
        n_lo_gt   = r_lo_gt;
        n_res_hit = r_res_hit;
        n_res_idx = r_res_idx;
        w_mem_we  = 1'b0;
        w_raddr   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.op == stfs_pkg::OP_LOOKUP) begin
                        n_key   = i_cmd.tval;
                        n_lo    = '0;
                        n_hi    = w_hi_eff;
                        n_state = S_LO;
                    end else begin
                        w_mem_we = 1'b1;
                    end
                end
            end
            S_LO: begin
                if (w_eq) begin
                    n_res_hit = 1'b1;
                    n_res_idx = r_lo;
                    n_state   = S_OUT;
                end else begin
                    n_lo_gt = w_gt;
                    w_raddr = r_hi;
                    n_state = S_HI;
                end
            end
            S_HI: begin
                priority if (w_eq) begin
                    n_res_hit = 1'b1;
                    n_res_idx = r_hi;
                    n_state   = S_OUT;
                end else if (r_lo_gt || w_lt) begin
                    n_res_hit = 1'b0;
                    n_res_idx = '0;
                    n_state   = S_OUT;
                end else if (w_wide) begin
                    n_mid   = w_mid;
                    w_raddr = w_mid;
                    n_state = S_MID;
                end else begin
                    n_res_hit = 1'b1;
                    n_res_idx = r_lo;
                    n_state   = S_OUT;
                end
            end
            S_MID: begin
                priority if (w_eq) begin
                    n_res_hit = 1'b1;
                    n_res_idx = r_mid;
                    n_state   = S_OUT;
                end else if (w_wide) begin
                    n_lo    = w_span_lo;
                    n_hi    = w_span_hi;
                    n_mid   = w_mid;
                    w_raddr = w_mid;
                end else begin
                    n_res_hit = 1'b1;
                    n_res_idx = w_span_lo;
                    n_state   = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        if (w_out_load) begin
            n_out_valid = 1'b1;
        end
    end

    assign w_idx_ext = XW'(r_res_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_entry_count <= stfs_pkg::COUNT_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_entry_count <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_mid     <= n_mid;
        r_lo_gt   <= n_lo_gt;
        r_res_hit <= n_res_hit;
        r_res_idx <= n_res_idx;
        if (w_out_load) begin
            r_out_hit <= r_res_hit;
            r_out_idx <= r_res_hit ? w_idx_ext[stfs_pkg::SLOT_W-1:0] : '0;
        end
    end

    // table with one write port and one read port, registered read
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_table[w_waddr] <= i_cmd.tval;
        end
        r_rdata <= r_table[w_raddr];
    end

    assign o_valid       = r_out_valid;
    assign o_in_range    = r_out_hit;
    assign o_found_index = r_out_idx;

endmodule

// ===== sv/sorted_time_floor_search_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_time_floor_search_unit
// Table of ascending timestamps with floor (predecessor) lookup.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_ready): a word with i_mode low stores
// i_time_value at slot i_entry_index and gives no result; slots at or past
// TABLE_DEPTH are ignored. A word with i_mode high looks up i_time_value.
// Output channel (o_valid / i_ready): one word per lookup, o_in_range and
// o_found_index (exact match or nearest lower slot, zero when out of range).
// i_cfg_we / i_cfg_wdata set the entry count; write it only while idle.
// An input register and a two-entry queue feed the search engine, which
// does table writes from its idle state. A lookup reads the first entry,
// the last entry, then one midpoint per cycle through the single table
// read port. Up to three further words are taken while a lookup runs or a
// result waits; a stalled receiver holds the result in the output register
// and the engine waits on it. Reset clears the queue, the result and sets
// the entry count to one; table contents stay undefined until written.
// ----------------------------------------------------------------------------
module sorted_time_floor_search_unit #(
    parameter int TABLE_DEPTH = stfs_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [stfs_pkg::COUNT_W-1:0]  i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_mode,
    input  logic [stfs_pkg::SLOT_W-1:0]   i_entry_index,
    input  logic [stfs_pkg::TIME_W-1:0]   i_time_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_in_range,
    output logic [stfs_pkg::SLOT_W-1:0]   o_found_index
);

    logic           w_front_valid;
    logic           w_front_ready;
    stfs_pkg::t_cmd w_front_cmd;
    logic           w_queue_valid;
    logic           w_queue_ready;
    stfs_pkg::t_cmd w_queue_cmd;

    stfs_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_mode        (i_mode),
        .i_entry_index (i_entry_index),
        .i_time_value  (i_time_value),
        .o_cmd_valid   (w_front_valid),
        .i_cmd_ready   (w_front_ready),
        .o_cmd         (w_front_cmd)
    );

    stfs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_front_valid),
        .o_ready (w_front_ready),
        .i_cmd   (w_front_cmd),
        .o_valid (w_queue_valid),
        .i_ready (w_queue_ready),
        .o_cmd   (w_queue_cmd)
    );

    stfs_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_cmd_valid   (w_queue_valid),
        .o_cmd_ready   (w_queue_ready),
        .i_cmd         (w_queue_cmd),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_in_range    (o_in_range),
        .o_found_index (o_found_index)
    );

endmodule

// ===== sv/stfs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stfs_checker
// Port level checks of the time search unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "sorted_time_floor_search_unit_defines.svh"

module stfs_checker #(
    parameter int TABLE_DEPTH = stfs_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          o_ready,
    input  logic                          o_valid,
    input  logic                          i_ready,
    input  logic                          o_in_range,
    input  logic [stfs_pkg::SLOT_W-1:0]   o_found_index
);

    // a stalled result word holds
    `STFS_ASSERT(a_out_hold, o_valid && !i_ready |=> o_valid && $stable(o_in_range) && $stable(o_found_index))

    // out of range results carry index zero
    `STFS_ASSERT(a_miss_zero, o_valid && !o_in_range |-> o_found_index == '0)

    // a found index always lies inside the table
    `STFS_ASSERT(a_idx_bound, o_valid && o_in_range |-> 32'(o_found_index) < TABLE_DEPTH)

    // reset empties the result and opens the input
    `STFS_ASSERT_RST(a_reset_clear, !i_rst_n |=> !o_valid && o_ready)

endmodule

bind sorted_time_floor_search_unit stfs_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_stfs_checker (.*);
